[rtl/core/mh2_pkg.sv]
package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;
  localparam logic [7:0]  BYTE_MASK   = 8'hff;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // what the back end does with a word
  typedef enum logic [1:0] {
    OP_WORD      = 2'd0,  // full word mix, no result
    OP_LAST_WORD = 2'd1,  // full word mix, then finalize
    OP_TAIL      = 2'd2,  // 1 to 3 tail bytes, then finalize
    OP_FIN       = 2'd3   // finalize only
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        first;
    logic [31:0] init;     // seed ^ length, used when first is set
    logic [31:0] operand;  // mixed k, or masked tail bytes
  } entry_t;

  function automatic logic [31:0] mul_m(input logic [31:0] a);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, MIX_MUL};
    return p[31:0];
  endfunction

endpackage

[rtl/core/mh2_front.sv]
module mh2_front import mh2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [31:0] total_length,
  output logic        push,
  output entry_t      push_entry,
  input  logic        q_ready
);

  logic [31:0] seed;

  logic        a_valid, b_valid, c_valid;
  op_t         a_op, b_op;
  logic        a_first, b_first;
  logic [31:0] a_init, b_init;
  logic [31:0] a_data, b_data;
  entry_t      c_entry;

  logic c_free, b_free, a_free, accept;
  op_t  in_op;
  logic [31:0] tail_bytes, b_mixed;

  assign c_free   = !c_valid || q_ready;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign in_stall = !a_free;
  assign accept   = in_valid && a_free;

  always_comb begin
    if (!last_word) begin
      in_op = OP_WORD;
    end else if (byte_count == 3'd0) begin
      in_op = OP_FIN;
    end else if (byte_count inside {[3'd1:3'd3]}) begin
      in_op = OP_TAIL;
    end else begin
      in_op = OP_LAST_WORD;
    end
  end

  always_comb begin
    tail_bytes = {24'd0, data_word[7:0] & BYTE_MASK};
    if (byte_count >= 3'd2) tail_bytes[15:8]  = data_word[15:8];
    if (byte_count >= 3'd3) tail_bytes[23:16] = data_word[23:16];
  end

  assign b_mixed = b_data ^ (b_data >> MIX_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed    <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (cfg_we) seed <= cfg_wdata;
      if (a_free) a_valid <= in_valid;
      if (b_free) b_valid <= a_valid;
      if (c_free) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op    <= in_op;
      a_first <= first_word;
      a_init  <= seed ^ total_length;
      a_data  <= (in_op == OP_TAIL) ? tail_bytes : data_word;
    end
    if (b_free && a_valid) begin
      b_op    <= a_op;
      b_first <= a_first;
      b_init  <= a_init;
      b_data  <= (a_op == OP_WORD || a_op == OP_LAST_WORD) ? mul_m(a_data) : a_data;
    end
    if (c_free && b_valid) begin
      c_entry.op      <= b_op;
      c_entry.first   <= b_first;
      c_entry.init    <= b_init;
      c_entry.operand <= (b_op == OP_WORD || b_op == OP_LAST_WORD) ? mul_m(b_mixed) : b_data;
    end
  end

  assign push       = c_valid;
  assign push_entry = c_entry;

endmodule

[rtl/core/mh2_queue.sv]
module mh2_queue import mh2_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   q_ready,
  input  logic   pop,
  output logic   q_valid,
  output entry_t pop_entry
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign q_ready   = count != QCNT_W'(QUEUE_DEPTH);
  assign q_valid   = count != '0;
  assign do_push   = push && q_ready;
  assign do_pop    = pop && q_valid;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

[rtl/core/mh2_back.sv]
module mh2_back import mh2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      pop_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MIX  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t      state, state_next;
  logic [31:0] running_hash;
  logic [31:0] prod;
  op_t         cur_op;
  logic [31:0] cur_operand;

  logic [31:0] h0, h1, mul_a, fin_res;
  logic        load_prod, out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && q_valid;
  assign h0       = pop_entry.first ? pop_entry.init : running_hash;
  assign h1       = (cur_op == OP_TAIL) ? prod : prod ^ cur_operand;
  assign fin_res  = prod ^ (prod >> FIN_SHIFT_B);

  // one shared multiplier: word/tail mix or finalize-only avalanche from idle, avalanche from mix
  always_comb begin
    state_next = state;
    load_prod  = 1'b0;
    mul_a      = h1 ^ (h1 >> FIN_SHIFT_A);
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          load_prod = 1'b1;
          case (pop_entry.op)
            OP_FIN: begin
              mul_a      = h0 ^ (h0 >> FIN_SHIFT_A);
              state_next = ST_FIN;
            end
            OP_TAIL: begin
              mul_a      = h0 ^ pop_entry.operand;
              state_next = ST_MIX;
            end
            default: begin
              mul_a      = h0;
              state_next = ST_MIX;
            end
          endcase
        end
      end
      ST_MIX: begin
        if (cur_op == OP_WORD) begin
          state_next = ST_IDLE;
        end else begin
          load_prod  = 1'b1;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MIX && cur_op == OP_WORD) running_hash <= h1;
      if (state == ST_FIN && out_free) begin
        running_hash <= fin_res;
        out_valid    <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_prod) prod <= mul_m(mul_a);
    if (pop) begin
      cur_op      <= pop_entry.op;
      cur_operand <= pop_entry.operand;
    end
    if (state == ST_FIN && out_free) hash_value <= fin_res;
  end

endmodule

[rtl/core/murmur2_hash32_engine_top.sv]
// MurmurHash2 32-bit engine: front mixes each word in a 3-stage pipe, back updates h.
// A hashing word passes front stages a, b and c, the queue, back states ST_MIX and ST_FIN
// (only ST_FIN on a last word with count 0), then the output register that drives out_valid.
// The back end takes a new word only from ST_IDLE, after the last one is through, as set by
// the single shared multiplier in the hash update loop; ST_FIN also waits on out_stall.
// Reset (synchronous): seed and running hash go to zero, queue and pipes empty.
module murmur2_hash32_engine_top import mh2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [31:0] total_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value
);

  logic   push, q_ready, q_valid, pop;
  entry_t push_entry, pop_entry;

  mh2_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .first_word   (first_word),
    .last_word    (last_word),
    .total_length (total_length),
    .push         (push),
    .push_entry   (push_entry),
    .q_ready      (q_ready)
  );

  mh2_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .pop_entry  (pop_entry)
  );

  mh2_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule

[tb/tb.sv]
module tb;
  import mh2_pkg::*;

  localparam int DIR_N          = 21;
  localparam int PHASES         = 8;
  localparam int RAND_PER_PHASE = 60;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 300000;

  // seeds used on the even phases; odd phases take a random seed
  localparam logic [3:0][31:0] EDGE_SEEDS = {32'h00000001, 32'h80000000,
                                             32'h00000000, 32'hffffffff};

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        is_first;
    logic        is_last;
    logic [31:0] len;
    logic        known;   // hash typed in below
    logic [31:0] hash;
  } stim_row_t;

  stim_row_t dir_rows [DIR_N] = '{
    // after reset, no first word: finalize of zero
    '{32'hffffffff, 3'd0, 1'b0, 1'b1, 32'hffffffff, 1'b1, 32'h00000000},
    // zero seed, zero length, empty message
    '{32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h00000000, 1'b1, 32'h00000000},
    '{32'h00000000, 3'd4, 1'b1, 1'b0, 32'h00000008, 1'b0, 32'h0},
    '{32'hffffffff, 3'd4, 1'b0, 1'b1, 32'h00000000, 1'b0, 32'h0},
    // tail of one byte, upper bytes ignored
    '{32'hdeadbeef, 3'd1, 1'b1, 1'b1, 32'h00000001, 1'b0, 32'h0},
    '{32'h12345678, 3'd4, 1'b1, 1'b0, 32'h00000007, 1'b0, 32'h0},
    '{32'hffffffff, 3'd3, 1'b0, 1'b1, 32'h00000000, 1'b0, 32'h0},
    '{32'haabbccdd, 3'd2, 1'b1, 1'b1, 32'hffffffff, 1'b0, 32'h0},
    '{32'h80000001, 3'd4, 1'b1, 1'b1, 32'h00000004, 1'b0, 32'h0},
    // counts above four on a last word act as four
    '{32'h7fffffff, 3'd5, 1'b1, 1'b1, 32'h00000004, 1'b0, 32'h0},
    '{32'hffffffff, 3'd6, 1'b1, 1'b1, 32'h80000000, 1'b0, 32'h0},
    '{32'h01020304, 3'd7, 1'b1, 1'b1, 32'h00000004, 1'b0, 32'h0},
    // no first word: carries on from the finalized hash
    '{32'h55555555, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0, 32'h0},
    '{32'haaaaaaaa, 3'd0, 1'b0, 1'b1, 32'h00000000, 1'b0, 32'h0},
    // non-last words are mixed whole whatever the count
    '{32'h0000ffff, 3'd0, 1'b1, 1'b0, 32'h00000005, 1'b0, 32'h0},
    '{32'hffff0000, 3'd2, 1'b0, 1'b0, 32'h00000005, 1'b0, 32'h0},
    '{32'h000000ab, 3'd1, 1'b0, 1'b1, 32'h00000005, 1'b0, 32'h0},
    // message cut short by a new first word
    '{32'hcafef00d, 3'd7, 1'b1, 1'b0, 32'h00000000, 1'b0, 32'h0},
    '{32'h0badf00d, 3'd3, 1'b1, 1'b1, 32'h12345678, 1'b0, 32'h0},
    '{32'h00000001, 3'd4, 1'b1, 1'b1, 32'h00000000, 1'b0, 32'h0},
    '{32'h80000000, 3'd3, 1'b0, 1'b1, 32'h00000000, 1'b0, 32'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        first_word = 1'b0;
  logic        last_word = 1'b0;
  logic [31:0] total_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] hash_value;

  logic [31:0] seed_copy = '0;
  logic [31:0] hash_state = '0;
  logic [31:0] pending_hashes [$];
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int          words_sent = 0;
  int          errors = 0;
  int          cycle_count = 0;

  murmur2_hash32_engine_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .first_word   (first_word),
    .last_word    (last_word),
    .total_length (total_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hash_value   (hash_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] times_m(input logic [31:0] a);
    logic [31:0] p;
    p = a * MIX_MUL;
    return p;
  endfunction

  function automatic logic [31:0] mix_word32(input logic [31:0] h, input logic [31:0] k);
    k = times_m(k);
    k ^= k >> MIX_SHIFT;
    k = times_m(k);
    return times_m(h) ^ k;
  endfunction

  // advances hash_state by one word; returns 1 when the word yields a hash
  function automatic bit murmur_step(input logic [31:0] w, input logic [2:0] cnt,
                                     input logic is_first, input logic is_last,
                                     input logic [31:0] len, output logic [31:0] digest);
    logic [31:0] h;
    h = is_first ? (seed_copy ^ len) : hash_state;
    digest = '0;
    if (!is_last) begin
      hash_state = mix_word32(h, w);
      return 1'b0;
    end
    if (cnt >= 3'd4) begin
      h = mix_word32(h, w);
    end else if (cnt != 3'd0) begin
      h = times_m(h ^ (w & (32'hffffffff >> (32 - 8 * cnt))));
    end
    h ^= h >> FIN_SHIFT_A;
    h = times_m(h);
    h ^= h >> FIN_SHIFT_B;
    hash_state = h;
    digest = h;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic is_first,
                           input logic is_last, input logic [31:0] len,
                           input logic known, input logic [31:0] known_hash);
    logic [31:0] digest;
    bit taken;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_word    <= w;
    byte_count   <= cnt;
    first_word   <= is_first;
    last_word    <= is_last;
    total_length <= len;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (murmur_step(w, cnt, is_first, is_last, len, digest))
      pending_hashes = {pending_hashes, (known ? known_hash : digest)};
    words_sent++;
  endtask

  // message of random length, sometimes with a false length or a random count on a full word
  task automatic send_message();
    int unsigned msg_len;
    int unsigned n_full;
    int unsigned tail;
    int unsigned idx;
    bit empty_close;
    logic [31:0] len_field;
    logic [2:0] cnt;
    if ($urandom_range(9) == 0)
      msg_len = $urandom_range(200, 64);
    else
      msg_len = $urandom_range(24, 0);
    len_field = ($urandom_range(9) == 0) ? $urandom : msg_len;
    n_full = msg_len / 4;
    tail = msg_len % 4;
    // a multiple of four may still close with an empty last word
    empty_close = (n_full == 0) || (tail != 0) || ($urandom_range(1) == 1);
    for (idx = 0; idx < n_full; idx++) begin
      cnt = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'd4;
      send_word($urandom, cnt, idx == 0, !empty_close && idx == n_full - 1,
                idx == 0 ? len_field : $urandom, 1'b0, 32'h0);
    end
    if (empty_close)
      send_word($urandom, 3'(tail), n_full == 0, 1'b1,
                n_full == 0 ? len_field : $urandom, 1'b0, 32'h0);
  endtask

  task automatic write_seed(input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    // words that make no hash may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seed_copy = value;
  endtask

  always @(posedge clk) begin
    out_stall <= $urandom_range(99) < recv_pct;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected hash_value %h", hash_value));
      end else begin
        want = pending_hashes.pop_front();
        if (hash_value !== want)
          report_mismatch($sformatf("hash_value %h, expected %h", hash_value, want));
      end
    end
  end

  initial begin
    int p;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].count, dir_rows[i].is_first,
                dir_rows[i].is_last, dir_rows[i].len, dir_rows[i].known, dir_rows[i].hash);
    for (p = 0; p < PHASES; p++) begin
      write_seed((p % 2 == 0) ? EDGE_SEEDS[p / 2] : $urandom);
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 53; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 53; end
        default: begin send_pct = 31; recv_pct = 31; end
      endcase
      while (words_sent < DIR_N + (p + 1) * RAND_PER_PHASE) begin
        if ($urandom_range(99) < 80)
          send_message();
        else
          send_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), $urandom, 1'b0, 32'h0);
      end
    end
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
